/* design/lcabl_pkg.sv */
// Shared constants for the binary-lifting lowest-common-ancestor block.
package lcabl_pkg;

   localparam int NODE_BITS_DEFAULT = 10;
   localparam int LEVELS_DEFAULT    = 10;

   localparam int CFG_BITS = 4;
   localparam logic [CFG_BITS-1:0] LIFT_LEVELS_RESET = 4'd9;

   localparam logic OP_ATTACH = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

endpackage

/* design/lcabl_mem.sv */
// Depth table and ancestor-jump table, one write and one registered read port each.
module lcabl_mem #(
   parameter int NODE_BITS = lcabl_pkg::NODE_BITS_DEFAULT,
   parameter int LVL_BITS  = 4
) (
   input  logic                          clock,
   input  logic                          dep_we,
   input  logic [NODE_BITS-1:0]          dep_waddr,
   input  logic [NODE_BITS-1:0]          dep_wdata,
   input  logic [NODE_BITS-1:0]          dep_raddr,
   output logic [NODE_BITS-1:0]          dep_rdata,
   input  logic                          anc_we,
   input  logic [NODE_BITS+LVL_BITS-1:0] anc_waddr,
   input  logic [NODE_BITS-1:0]          anc_wdata,
   input  logic [NODE_BITS+LVL_BITS-1:0] anc_raddr,
   output logic [NODE_BITS-1:0]          anc_rdata
);

   localparam int AW        = NODE_BITS + LVL_BITS;
   localparam int DEP_DEPTH = 2 ** NODE_BITS;
   localparam int ANC_DEPTH = 2 ** AW;

   logic [NODE_BITS-1:0] dep_mem [DEP_DEPTH];
   logic [NODE_BITS-1:0] anc_mem [ANC_DEPTH];

   logic [NODE_BITS-1:0] dep_q_ff;
   logic [NODE_BITS-1:0] dep_wd_ff;
   logic                 dep_zero_ff;
   logic                 dep_byp_ff;
   logic [NODE_BITS-1:0] anc_q_ff;
   logic [NODE_BITS-1:0] anc_wd_ff;
   logic                 anc_zero_ff;
   logic                 anc_byp_ff;

   // node zero is the sentinel: never written, always reads as zero
   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_waddr] <= dep_wdata;
      end
      dep_q_ff    <= dep_mem[dep_raddr];
      dep_wd_ff   <= dep_wdata;
      dep_zero_ff <= (dep_raddr == '0);
      dep_byp_ff  <= dep_we && (dep_waddr == dep_raddr);
   end

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_q_ff    <= anc_mem[anc_raddr];
      anc_wd_ff   <= anc_wdata;
      anc_zero_ff <= (anc_raddr[AW-1:LVL_BITS] == '0);
      anc_byp_ff  <= anc_we && (anc_waddr == anc_raddr);
   end

   assign dep_rdata = dep_zero_ff ? '0 : (dep_byp_ff ? dep_wd_ff : dep_q_ff);
   assign anc_rdata = anc_zero_ff ? '0 : (anc_byp_ff ? anc_wd_ff : anc_q_ff);

endmodule

/* design/lcabl_seq.sv */
// Sequencer for attach and query words, driving the table ports and the result register.
module lcabl_seq #(
   parameter int NODE_BITS = lcabl_pkg::NODE_BITS_DEFAULT,
   parameter int LEVELS    = lcabl_pkg::LEVELS_DEFAULT,
   parameter int LVL_BITS  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [LVL_BITS-1:0]           top_lvl,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [NODE_BITS-1:0]          req_node_a,
   input  logic [NODE_BITS-1:0]          req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NODE_BITS-1:0]          rsp_ancestor,
   output logic                          dep_we,
   output logic [NODE_BITS-1:0]          dep_waddr,
   output logic [NODE_BITS-1:0]          dep_wdata,
   output logic [NODE_BITS-1:0]          dep_raddr,
   input  logic [NODE_BITS-1:0]          dep_rdata,
   output logic                          anc_we,
   output logic [NODE_BITS+LVL_BITS-1:0] anc_waddr,
   output logic [NODE_BITS-1:0]          anc_wdata,
   output logic [NODE_BITS+LVL_BITS-1:0] anc_raddr,
   input  logic [NODE_BITS-1:0]          anc_rdata
);

   localparam int EQ_BITS = (NODE_BITS < LEVELS) ? NODE_BITS : LEVELS;
   localparam logic [LVL_BITS-1:0] EQ_LAST = LVL_BITS'(EQ_BITS - 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_A_DEP = 4'd1;
   localparam logic [3:0] S_A_JMP = 4'd2;
   localparam logic [3:0] S_Q_DA  = 4'd3;
   localparam logic [3:0] S_Q_DB  = 4'd4;
   localparam logic [3:0] S_Q_EQ  = 4'd5;
   localparam logic [3:0] S_Q_EJ  = 4'd6;
   localparam logic [3:0] S_Q_ED  = 4'd7;
   localparam logic [3:0] S_Q_CMP = 4'd8;
   localparam logic [3:0] S_Q_LU  = 4'd9;
   localparam logic [3:0] S_Q_LV  = 4'd10;
   localparam logic [3:0] S_Q_FIN = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [NODE_BITS-1:0] u_ff, u_in;
   logic [NODE_BITS-1:0] v_ff, v_in;
   logic [NODE_BITS-1:0] du_ff, du_in;
   logic [NODE_BITS-1:0] dv_ff, dv_in;
   logic [NODE_BITS-1:0] ju_ff, ju_in;
   logic [NODE_BITS-1:0] res_ff, res_in;
   logic [LVL_BITS-1:0]  lvl_ff, lvl_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0] rsp_ancestor_ff, rsp_ancestor_in;

   logic [LVL_BITS-1:0]  lvl_up;
   logic [LVL_BITS-1:0]  lvl_dn;
   logic [NODE_BITS-1:0] diff_bits;
   logic [NODE_BITS-1:0] u_pick;
   logic [NODE_BITS-1:0] v_pick;

   assign lvl_up    = lvl_ff + 1'b1;
   assign lvl_dn    = lvl_ff - 1'b1;
   assign diff_bits = (du_ff ^ dv_ff) >> lvl_ff;
   assign u_pick    = (ju_ff != anc_rdata) ? ju_ff : u_ff;
   assign v_pick    = (ju_ff != anc_rdata) ? anc_rdata : v_ff;

   always_comb begin
      state_in        = state_ff;
      node_in         = node_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      du_in           = du_ff;
      dv_in           = dv_ff;
      ju_in           = ju_ff;
      res_in          = res_ff;
      lvl_in          = lvl_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_ancestor_in = rsp_ancestor_ff;
      dep_we          = 1'b0;
      dep_waddr       = node_ff;
      dep_wdata       = dep_rdata + NODE_BITS'(1);
      dep_raddr       = u_ff;
      anc_we          = 1'b0;
      anc_waddr       = {node_ff, lvl_up};
      anc_wdata       = anc_rdata;
      anc_raddr       = {u_ff, lvl_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               node_in = req_node_a;
               v_in    = req_node_b;
               lvl_in  = '0;
               if (req_opcode == lcabl_pkg::OP_ATTACH) begin
                  u_in = req_node_b;
                  if (req_node_a != '0) begin
                     dep_raddr = req_node_b;
                     anc_we    = 1'b1;
                     anc_waddr = {req_node_a, {LVL_BITS{1'b0}}};
                     anc_wdata = req_node_b;
                     state_in  = S_A_DEP;
                  end
               end else begin
                  u_in      = req_node_a;
                  dep_raddr = req_node_a;
                  state_in  = S_Q_DA;
               end
            end
         end
         S_A_DEP: begin
            dep_we = 1'b1;
            if (top_lvl == '0) begin
               state_in = S_IDLE;
            end else begin
               anc_raddr = {u_ff, {LVL_BITS{1'b0}}};
               state_in  = S_A_JMP;
            end
         end
         S_A_JMP: begin
            anc_we    = 1'b1;
            anc_waddr = {node_ff, lvl_up};
            anc_wdata = anc_rdata;
            u_in      = anc_rdata;
            lvl_in    = lvl_up;
            anc_raddr = {anc_rdata, lvl_up};
            if (lvl_up == top_lvl) begin
               state_in = S_IDLE;
            end
         end
         S_Q_DA: begin
            du_in     = dep_rdata;
            dep_raddr = v_ff;
            state_in  = S_Q_DB;
         end
         S_Q_DB: begin
            if (dep_rdata > du_ff) begin
               u_in  = v_ff;
               v_in  = u_ff;
               du_in = dep_rdata;
               dv_in = du_ff;
            end else begin
               dv_in = dep_rdata;
            end
            lvl_in   = '0;
            state_in = S_Q_EQ;
         end
         S_Q_EQ: begin
            priority if (du_ff <= dv_ff) begin
               state_in = S_Q_CMP;
            end else if (diff_bits[0]) begin
               anc_raddr = {u_ff, lvl_ff};
               state_in  = S_Q_EJ;
            end else if (lvl_ff == EQ_LAST) begin
               state_in = S_Q_CMP;
            end else begin
               lvl_in = lvl_up;
            end
         end
         S_Q_EJ: begin
            u_in      = anc_rdata;
            dep_raddr = anc_rdata;
            state_in  = S_Q_ED;
         end
         S_Q_ED: begin
            du_in = dep_rdata;
            if (lvl_ff == EQ_LAST) begin
               state_in = S_Q_CMP;
            end else begin
               lvl_in   = lvl_up;
               state_in = S_Q_EQ;
            end
         end
         S_Q_CMP: begin
            if (u_ff == v_ff) begin
               res_in   = u_ff;
               state_in = S_OUT;
            end else begin
               lvl_in    = top_lvl;
               anc_raddr = {u_ff, top_lvl};
               state_in  = S_Q_LU;
            end
         end
         S_Q_LU: begin
            ju_in     = anc_rdata;
            anc_raddr = {v_ff, lvl_ff};
            state_in  = S_Q_LV;
         end
         S_Q_LV: begin
            u_in = u_pick;
            v_in = v_pick;
            if (lvl_ff == '0) begin
               anc_raddr = {u_pick, {LVL_BITS{1'b0}}};
               state_in  = S_Q_FIN;
            end else begin
               lvl_in    = lvl_dn;
               anc_raddr = {u_pick, lvl_dn};
               state_in  = S_Q_LU;
            end
         end
         S_Q_FIN: begin
            res_in   = anc_rdata;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_ancestor_in = res_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff         <= node_in;
      u_ff            <= u_in;
      v_ff            <= v_in;
      du_ff           <= du_in;
      dv_ff           <= dv_in;
      ju_ff           <= ju_in;
      res_ff          <= res_in;
      lvl_ff          <= lvl_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;

endmodule

/* design/lca_binary_lifting.sv */
// Top level of the binary-lifting lowest-common-ancestor block.
// Keeps a depth and a table of power-of-two ancestor jumps for each node and answers
// lowest-common-ancestor queries. An attach word (opcode 0) places node_a under node_b,
// which must already be attached (the root goes under node 0), and gives no result; a
// query word (opcode 1) gives one result word. One word is in work at a time and
// req_stall is high while it runs; a finished result waits in the output register and
// does not hold up the next word. The steps read through the single read port of the
// depth table and that of the jump table. An attach writes the first jump entry of
// node_a as it is taken, then its depth, then one jump entry per level up to top; an
// attach of node 0 writes nothing. A query reads both depths, lifts the deeper node over
// each set bit of the depth difference, and, when the two nodes have not met by then,
// lifts both together from level top down and reads the parent at the end; top is
// csr_lift_levels capped at LEVELS-1. A query also waits while the output register
// holds a stalled result. Entries other than node 0 must be written before they are
// read; there is no clearing pass after reset.
module lca_binary_lifting #(
   parameter int NODE_BITS = lcabl_pkg::NODE_BITS_DEFAULT,
   parameter int LEVELS    = lcabl_pkg::LEVELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [NODE_BITS-1:0]          req_node_a,
   input  logic [NODE_BITS-1:0]          req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [NODE_BITS-1:0]          rsp_ancestor,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lcabl_pkg::CFG_BITS-1:0] csr_lift_levels
);

   localparam int LVL_BITS = $clog2(LEVELS);
   localparam int AW       = NODE_BITS + LVL_BITS;

   logic [lcabl_pkg::CFG_BITS-1:0] lift_ff;
   logic [LVL_BITS-1:0]            top_lvl;

   logic                 dep_we;
   logic [NODE_BITS-1:0] dep_waddr;
   logic [NODE_BITS-1:0] dep_wdata;
   logic [NODE_BITS-1:0] dep_raddr;
   logic [NODE_BITS-1:0] dep_rdata;
   logic                 anc_we;
   logic [AW-1:0]        anc_waddr;
   logic [NODE_BITS-1:0] anc_wdata;
   logic [AW-1:0]        anc_raddr;
   logic [NODE_BITS-1:0] anc_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff <= lcabl_pkg::LIFT_LEVELS_RESET;
      end else if (csr_valid && csr_ready) begin
         lift_ff <= csr_lift_levels;
      end
   end

   always_comb begin
      if (32'(lift_ff) > 32'(LEVELS - 1)) begin
         top_lvl = LVL_BITS'(LEVELS - 1);
      end else begin
         top_lvl = LVL_BITS'(lift_ff);
      end
   end

   lcabl_seq #(
      .NODE_BITS (NODE_BITS),
      .LEVELS    (LEVELS),
      .LVL_BITS  (LVL_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .top_lvl      (top_lvl),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_node_a   (req_node_a),
      .req_node_b   (req_node_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ancestor (rsp_ancestor),
      .dep_we       (dep_we),
      .dep_waddr    (dep_waddr),
      .dep_wdata    (dep_wdata),
      .dep_raddr    (dep_raddr),
      .dep_rdata    (dep_rdata),
      .anc_we       (anc_we),
      .anc_waddr    (anc_waddr),
      .anc_wdata    (anc_wdata),
      .anc_raddr    (anc_raddr),
      .anc_rdata    (anc_rdata)
   );

   lcabl_mem #(
      .NODE_BITS (NODE_BITS),
      .LVL_BITS  (LVL_BITS)
   ) u_mem (
      .clock     (clock),
      .dep_we    (dep_we),
      .dep_waddr (dep_waddr),
      .dep_wdata (dep_wdata),
      .dep_raddr (dep_raddr),
      .dep_rdata (dep_rdata),
      .anc_we    (anc_we),
      .anc_waddr (anc_waddr),
      .anc_wdata (anc_wdata),
      .anc_raddr (anc_raddr),
      .anc_rdata (anc_rdata)
   );

endmodule
